// ===== sv/cbm_pkg.sv =====
package cbm_pkg;

  // Cartridge geometry.
  localparam int RAM_BANK_COUNT = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BYTES = 16384;
  localparam int STORE_BYTES    = RAM_BANK_COUNT * RAM_BANK_BYTES;

  // Address widths derived from the geometry.
  localparam int RAM_OFS_W  = $clog2(RAM_BANK_BYTES);
  localparam int ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
  localparam int RAM_AW     = $clog2(STORE_BYTES);
  localparam int RAM_FULL_W = RAM_OFS_W + 2;
  localparam int ROM_BANK_W = 7;
  localparam int ROM_ADDR_W = ROM_BANK_W + ROM_OFS_W;

  // Depth of the queue between decode and execution.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Bus regions, selected by the top three address bits.
  localparam logic [2:0] REGION_RAM_EN   = 3'b000;
  localparam logic [2:0] REGION_ROM_BANK = 3'b001;
  localparam logic [2:0] REGION_RAM_BANK = 3'b010;
  localparam logic [2:0] REGION_MODE     = 3'b011;

  localparam logic [15:0] ADDR_REGION_MASK = 16'hE000;
  localparam logic [15:0] ADDR_RAM_BASE    = 16'hA000;

  // Register field constants.
  localparam logic [3:0] RAM_EN_KEY    = 4'hA;
  localparam logic [4:0] ROM_BANK_ONE  = 5'd1;
  localparam logic [4:0] ROM_BANK_ZERO = 5'd0;

  // Result target codes.
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_t;

  // One decoded access, passed from decode to execution.
  typedef struct packed {
    target_t                 target;
    logic [ROM_ADDR_W-1:0]   rom_address;
    logic                    ram_rd;
    logic                    ram_we;
    logic [RAM_FULL_W-1:0]   ram_addr;
    logic [7:0]              ram_wdata;
  } cmd_t;

  // Reduce a RAM bank number to the banks actually fitted.
  function automatic logic [1:0] ram_bank_wrap(input logic [1:0] bank);
    logic [1:0] b;
    b = bank;
    for (int i = 0; i < 3; i++) begin
      if (32'(b) >= RAM_BANK_COUNT) begin
        b = b - 2'(RAM_BANK_COUNT);
      end
    end
    return b;
  endfunction

endpackage

// ===== sv/cbm_ram.sv =====
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, read-first; the read data holds while the port is idle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/cbm_front.sv =====
module cbm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_kind,
  input  logic [15:0]    in_address,
  input  logic [7:0]     in_write_data,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output cbm_pkg::cmd_t  cmd
);
  import cbm_pkg::*;

  logic [4:0] rom_bank_r, rom_bank_nxt;
  logic [1:0] ram_bank_r, ram_bank_nxt;
  logic       mode_r, mode_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic       accept;
  logic       in_ram;
  logic [2:0] region;
  logic [ROM_BANK_W-1:0] upper_bank;
  logic [1:0] ram_sel;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  assign region = in_address[15:13];
  assign in_ram = (in_address & ADDR_REGION_MASK) == ADDR_RAM_BASE;

  // Bank used for the switchable ROM window.
  assign upper_bank = mode_r ? {2'b00, rom_bank_r} : {ram_bank_r, rom_bank_r};

  // RAM bank: fixed at zero in mode 0.
  assign ram_sel = ram_bank_wrap(mode_r ? ram_bank_r : 2'b00);

  // Decode the access and work out the register updates it makes.
  always_comb begin
    rom_bank_nxt  = rom_bank_r;
    ram_bank_nxt  = ram_bank_r;
    mode_nxt      = mode_r;
    ram_en_nxt    = ram_en_r;
    cmd.target    = TGT_NONE;
    cmd.rom_address = '0;
    cmd.ram_rd    = 1'b0;
    cmd.ram_we    = 1'b0;
    cmd.ram_addr  = {ram_sel, in_address[RAM_OFS_W-1:0]};
    cmd.ram_wdata = in_write_data;
    if (in_kind == KIND_WRITE) begin
      case (region)
        REGION_RAM_EN: begin
          ram_en_nxt = in_write_data[3:0] == RAM_EN_KEY;
        end
        REGION_ROM_BANK: begin
          rom_bank_nxt = (in_write_data[4:0] == ROM_BANK_ZERO) ? ROM_BANK_ONE
                                                                : in_write_data[4:0];
        end
        REGION_RAM_BANK: begin
          ram_bank_nxt = in_write_data[1:0];
        end
        REGION_MODE: begin
          mode_nxt = in_write_data[0];
        end
        default: begin
          if (in_ram && ram_en_r) begin
            cmd.target = TGT_RAM;
            cmd.ram_we = 1'b1;
          end
        end
      endcase
    end else begin
      if (!in_address[15]) begin
        cmd.target = TGT_ROM;
        if (!in_address[14]) begin
          cmd.rom_address = ROM_ADDR_W'(in_address);
        end else begin
          cmd.rom_address = {upper_bank, in_address[ROM_OFS_W-1:0]};
        end
      end else if (in_ram && ram_en_r) begin
        cmd.target = TGT_RAM;
        cmd.ram_rd = 1'b1;
      end
    end
  end

  // Controller registers; a configuration write loads the banking mode directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= ROM_BANK_ONE;
      ram_bank_r <= 2'b00;
      mode_r     <= 1'b0;
      ram_en_r   <= 1'b0;
    end else begin
      if (accept) begin
        rom_bank_r <= rom_bank_nxt;
        ram_bank_r <= ram_bank_nxt;
        ram_en_r   <= ram_en_nxt;
      end
      if (cfg_we) begin
        mode_r <= cfg_data;
      end else if (accept) begin
        mode_r <= mode_nxt;
      end
    end
  end

endmodule

// ===== sv/cbm_queue.sv =====
module cbm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cbm_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cbm_pkg::cmd_t  pop_cmd
);
  import cbm_pkg::*;

  cmd_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/cbm_back.sv =====
module cbm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  cbm_pkg::cmd_t                  cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_target,
  output logic [cbm_pkg::ROM_ADDR_W-1:0] out_rom_address,
  output logic [7:0]                     out_read_data
);
  import cbm_pkg::*;

  logic                  hold_valid_r;
  target_t               hold_target_r;
  logic [ROM_ADDR_W-1:0] hold_rom_r;
  logic                  hold_rd_r;
  logic                  take;
  logic [7:0]            ram_rdata;

  // A new item enters the result stage whenever that stage is free or drains.
  assign cmd_ready = !hold_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;

  // The RAM port runs only when an item enters, so its read data holds under stall.
  cbm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (take && (cmd.ram_rd || cmd.ram_we)),
    .we    (cmd.ram_we),
    .addr  (cmd.ram_addr[RAM_AW-1:0]),
    .wdata (cmd.ram_wdata),
    .rdata (ram_rdata)
  );

  // Result stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (cmd_ready) begin
      hold_valid_r <= cmd_valid;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (take) begin
      hold_target_r <= cmd.target;
      hold_rom_r    <= cmd.rom_address;
      hold_rd_r     <= cmd.ram_rd;
    end
  end

  assign out_valid       = hold_valid_r;
  assign out_target      = hold_target_r;
  assign out_rom_address = hold_rom_r;
  assign out_read_data   = hold_rd_r ? ram_rdata : 8'h00;

endmodule

// ===== sv/cartridge_bank_mapper_unit.sv =====
// Cartridge bank mapper: takes one CPU bus access per item and returns one result per
// item, in order. Writes to 0x0000-0x7FFF update the RAM enable, ROM bank, RAM bank and
// banking mode; reads of 0x0000-0x7FFF return a physical ROM byte address; accesses to
// 0xA000-0xBFFF reach the internal cartridge RAM while it is enabled. The block accepts
// one item per clock when the result side keeps up; an accepted item is decoded into
// a two-entry queue, and from there it moves into the result register together with
// the registered read of the single-port RAM, where its result is offered. With the
// result side stalled, three items can wait inside before the input stalls. The RAM is
// not cleared after reset, so reading a byte that was never written returns an
// arbitrary value. cfg_we loads the banking mode from cfg_data; it should be used only
// while no items are in flight.
module cartridge_bank_mapper_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [15:0]                    in_address,
  input  logic [7:0]                     in_write_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_target,
  output logic [cbm_pkg::ROM_ADDR_W-1:0] out_rom_address,
  output logic [7:0]                     out_read_data
);
  import cbm_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // Decode and controller registers.
  cbm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  // Queue between decode and execution.
  cbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // RAM access and result register.
  cbm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (back_valid),
    .cmd_ready       (back_ready),
    .cmd             (back_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target      (out_target),
    .out_rom_address (out_rom_address),
    .out_read_data   (out_read_data)
  );

endmodule

// ===== tb/cartridge_bank_mapper_unit_tb.sv =====
`timescale 1ns / 100ps

module cartridge_bank_mapper_unit_tb;
  import cbm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RECENT_DEPTH = 16;

  // One expected answer of the mapper.
  typedef struct packed {
    target_t               target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;
  } bus_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_data = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_READ;
  logic [15:0]           in_address = '0;
  logic [7:0]            in_write_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_target;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic [7:0]            out_read_data;

  // Mirror of the mapper registers and the cartridge RAM.
  logic       init_mode_q;
  logic       mode_q;
  logic [4:0] rom_bank_q;
  logic [1:0] ram_bank_q;
  logic       ram_on;
  logic [7:0] ram_image [STORE_BYTES];
  bit         ram_written [STORE_BYTES];
  logic [RAM_OFS_W-1:0] recent_ofs [RAM_BANK_COUNT][RECENT_DEPTH];
  int         recent_cnt [RAM_BANK_COUNT];

  bus_result_t expected_bus_results[$];
  int          error_count = 0;
  int          hold_request = 0;
  int          tx_quiet = 0;

  cartridge_bank_mapper_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_address      (in_address),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target      (out_target),
    .out_rom_address (out_rom_address),
    .out_read_data   (out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Wait draw shared by both sides: mostly a random wait, with quiet runs of no wait.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
    end
    return $urandom_range(0, 17);
  endfunction

  // RAM bank the current mode selects, already reduced to the fitted banks.
  function automatic int effective_ram_bank();
    return mode_q ? int'(ram_bank_q) % RAM_BANK_COUNT : 0;
  endfunction

  function automatic int ram_slot(input logic [15:0] addr);
    return effective_ram_bank() * RAM_BANK_BYTES + int'(addr[RAM_OFS_W-1:0]);
  endfunction

  // Applies one bus access to the mirrored state and returns the answer it gives.
  function automatic bus_result_t predict_bus_access(input logic kind,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data);
    bus_result_t r;
    logic        in_ram;
    logic [6:0]  bank;
    int          slot;
    int          b;
    r.target      = TGT_NONE;
    r.rom_address = '0;
    r.read_data   = '0;
    in_ram = (addr & ADDR_REGION_MASK) == ADDR_RAM_BASE;
    slot   = ram_slot(addr);
    b      = effective_ram_bank();
    if (kind == KIND_WRITE) begin
      if (!addr[15]) begin
        case (addr[15:13])
          REGION_RAM_EN: ram_on = (data[3:0] == RAM_EN_KEY);
          REGION_ROM_BANK: begin
            rom_bank_q = (data[4:0] == ROM_BANK_ZERO) ? ROM_BANK_ONE : data[4:0];
          end
          REGION_RAM_BANK: ram_bank_q = data[1:0];
          default: mode_q = data[0];
        endcase
      end else if (in_ram && ram_on) begin
        ram_image[slot]   = data;
        ram_written[slot] = 1'b1;
        recent_ofs[b][recent_cnt[b] % RECENT_DEPTH] = addr[RAM_OFS_W-1:0];
        recent_cnt[b]++;
        r.target = TGT_RAM;
      end
    end else begin
      if (!addr[15]) begin
        r.target = TGT_ROM;
        if (!addr[14]) begin
          r.rom_address = ROM_ADDR_W'(addr);
        end else begin
          bank = mode_q ? {2'b00, rom_bank_q} : {ram_bank_q, rom_bank_q};
          r.rom_address = {bank, addr[ROM_OFS_W-1:0]};
        end
      end else if (in_ram && ram_on) begin
        r.target    = TGT_RAM;
        r.read_data = ram_image[slot];
      end
    end
    return r;
  endfunction

  // Offers one bus access and records its answer once the mapper takes it.
  // A read of a RAM byte never written is steered to a byte written in the same bank, or made a write if none was.
  task automatic send_access(input logic kind, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    int b;
    int n;
    if (kind == KIND_READ && ram_on && (addr & ADDR_REGION_MASK) == ADDR_RAM_BASE &&
        !ram_written[ram_slot(addr)]) begin
      b = effective_ram_bank();
      if (recent_cnt[b] > 0) begin
        n = (recent_cnt[b] < RECENT_DEPTH) ? recent_cnt[b] : RECENT_DEPTH;
        addr = ADDR_RAM_BASE | 16'(recent_ofs[b][$urandom_range(0, n - 1)]);
      end else begin
        kind = KIND_WRITE;
      end
    end
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_address    <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_bus_results.push_back(predict_bus_access(kind, addr, data));
  endtask

  // Waits until every answer has come back and the pipeline has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bus_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_banking_mode(input logic mode);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we      <= 1'b0;
    init_mode_q = mode;
    mode_q      = mode;
  endtask

  // One random access, weighted toward well-formed register and RAM traffic.
  task automatic send_random_access();
    int          sel;
    logic [15:0] addr;
    logic [7:0]  data;
    sel  = $urandom_range(0, 99);
    data = 8'($urandom);
    if (sel < 20) begin
      addr = 16'($urandom_range(0, 16'h7FFF));
      if (addr[15:13] == REGION_RAM_EN && $urandom_range(0, 3) != 0) begin
        data[3:0] = RAM_EN_KEY;
      end
      send_access(KIND_WRITE, addr, data);
    end else if (sel < 40) begin
      send_access(KIND_READ, 16'($urandom_range(0, 16'h7FFF)), data);
    end else if (sel < 62) begin
      send_access(KIND_WRITE, ADDR_RAM_BASE | 16'($urandom_range(0, 16'h1FFF)), data);
    end else if (sel < 85) begin
      send_access(KIND_READ, ADDR_RAM_BASE | 16'($urandom_range(0, 16'h1FFF)), data);
    end else begin
      send_access(1'($urandom), 16'($urandom), data);
    end
  endtask

  // Bank 0 window, switchable window in both modes, and the zero bank rule.
  task automatic test_rom_mapping();
    send_access(KIND_READ, 16'h0000, 8'h00);
    send_access(KIND_READ, 16'h3FFF, 8'hFF);
    send_access(KIND_READ, 16'h4000, 8'h00);
    send_access(KIND_WRITE, 16'h2000, 8'h00);
    send_access(KIND_READ, 16'h7FFF, 8'h00);
    send_access(KIND_WRITE, 16'h3FFF, 8'hFF);
    send_access(KIND_WRITE, 16'h5FFF, 8'hFF);
    send_access(KIND_READ, 16'h7FFF, 8'h00);
    send_access(KIND_WRITE, 16'h6000, 8'h01);
    send_access(KIND_READ, 16'h4000, 8'h00);
    send_access(KIND_WRITE, 16'h7FFF, 8'hFE);
  endtask

  // Disabled RAM, RAM at the window edges, the selected bank in mode 1.
  task automatic test_ram_access();
    send_access(KIND_READ, 16'hA000, 8'h00);
    send_access(KIND_WRITE, 16'hBFFF, 8'h55);
    send_access(KIND_WRITE, 16'h0000, 8'h0A);
    send_access(KIND_WRITE, 16'hA000, 8'h00);
    send_access(KIND_WRITE, 16'hBFFF, 8'hFF);
    send_access(KIND_READ, 16'hA000, 8'h00);
    send_access(KIND_READ, 16'hBFFF, 8'h00);
    send_access(KIND_WRITE, 16'h6000, 8'h01);
    send_access(KIND_WRITE, 16'hA123, 8'h5A);
    send_access(KIND_READ, 16'hA123, 8'h00);
    send_access(KIND_WRITE, 16'h1FFF, 8'hFB);
    send_access(KIND_READ, 16'hA123, 8'h00);
  endtask

  // Addresses outside every mapped window.
  task automatic test_unmapped();
    send_access(KIND_READ, 16'h8000, 8'h00);
    send_access(KIND_READ, 16'hC000, 8'h00);
    send_access(KIND_WRITE, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_access();
  endtask

  // The result side holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (40) send_random_access();
  endtask

  // Result side: random stalls, the long hold-off, and the field check.
  initial begin : result_sink
    int          stall_left;
    int          hold_left;
    int          rx_quiet;
    bus_result_t exp;
    stall_left = 0;
    hold_left  = 0;
    rx_quiet   = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_bus_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected item: target %0d rom_address %h read_data %h",
                     out_target, out_rom_address, out_read_data);
          end
        end else begin
          exp = expected_bus_results.pop_front();
          if (out_target !== exp.target || out_rom_address !== exp.rom_address ||
              out_read_data !== exp.read_data) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected target %0d rom_address %h read_data %h",
                       exp.target, exp.rom_address, exp.read_data);
              $display("          actual   target %0d rom_address %h read_data %h",
                       out_target, out_rom_address, out_read_data);
            end
          end
        end
        stall_left = draw_wait(rx_quiet);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when neither side moves an item for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : main
    init_mode_q = 1'b0;
    mode_q      = 1'b0;
    rom_bank_q  = ROM_BANK_ONE;
    ram_bank_q  = '0;
    ram_on      = 1'b0;
    for (int i = 0; i < RAM_BANK_COUNT; i++) recent_cnt[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_banking_mode(1'b0);
    test_rom_mapping();
    test_ram_access();
    test_unmapped();
    load_banking_mode(1'b1);
    test_random_traffic(260);
    load_banking_mode(1'b0);
    test_random_traffic(260);
    load_banking_mode(1'b1);
    test_backpressure();
    test_random_traffic(260);

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_bus_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cbm_pkg.sv
sv/cbm_ram.sv
sv/cbm_front.sv
sv/cbm_queue.sv
sv/cbm_back.sv
sv/cartridge_bank_mapper_unit.sv
tb/cartridge_bank_mapper_unit_tb.sv
